// ===== src/bds_pkg.sv =====
// Package for the baud divisor search block: shared widths, reset value and
// the sequencer state type. No dependencies.
package bds_pkg;

   localparam int DIVIDEND_WIDTH = 32;
   localparam int DIVISOR_WIDTH  = 40;
   localparam int PRESCALE_SHIFT = 3;

   localparam logic [31:0] REF_CLOCK_RESET = 32'd50000000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRE,
      ST_SPAN,
      ST_CD,
      ST_CD_WAIT,
      ST_RATE_MUL,
      ST_RATE,
      ST_RATE_WAIT,
      ST_NEXT,
      ST_FINISH
   } bds_state_type;

endpackage

// ===== src/bds_divider.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bds_pkg for the operand widths.
module bds_divider import bds_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DIVIDEND_WIDTH-1:0] dividend,
   input  logic [DIVISOR_WIDTH-1:0]  divisor,
   output logic                      done,
   output logic [DIVIDEND_WIDTH-1:0] quotient
);

   localparam int CountWidth = $clog2(DIVIDEND_WIDTH);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CountWidth-1:0]     count_ff, count_in;
   logic [DIVISOR_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_WIDTH-1:0] quo_ff, quo_in;
   logic [DIVISOR_WIDTH-1:0]  div_ff, div_in;
   logic [DIVISOR_WIDTH:0]    trial;
   logic [DIVISOR_WIDTH:0]    diff;

   // quo_ff holds the remaining dividend bits and collects quotient bits from the bottom
   assign trial = {rem_ff, quo_ff[DIVIDEND_WIDTH-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         div_in   = divisor;
      end else if (busy_ff) begin
         if (!diff[DIVISOR_WIDTH]) begin
            rem_in = diff[DIVISOR_WIDTH-1:0];
            quo_in = {quo_ff[DIVIDEND_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_WIDTH-1:0];
            quo_in = {quo_ff[DIVIDEND_WIDTH-2:0], 1'b0};
         end
         count_in = count_ff + CountWidth'(1);
         if (count_ff == CountWidth'(DIVIDEND_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/baud_divisor_search.sv =====
// Top level of the baud divisor search; uses bds_pkg and bds_divider.
// One sequencer drives a single shared bit-serial divider.
//
// For each requested baud rate the block picks a clock divisor and a bit divider
// whose rate lies closest to the request, using the reference clock written
// through the csr_ port (reset value 50 MHz). Every division goes through the
// single bit-serial divider. After the prescale decision, each bit divider tried
// takes one division for its clock divisor and, when that falls inside the allowed
// range, a second division for the achieved rate; a full search covers dividers
// 4 to 255, and an exact match ends the search early. The block takes a new item
// once the previous result has moved to the output register.
module baud_divisor_search import bds_pkg::*; #(
   parameter int DIVIDER_MIN       = 4,
   parameter int DIVIDER_MAX       = 255,
   parameter int CLOCK_DIVISOR_MAX = 65535
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_reference_clock_hz,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_desired_baud,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_prescale_by_eight,
   output logic [15:0] rsp_clock_divisor,
   output logic [7:0]  rsp_bit_divider,
   output logic [31:0] rsp_achieved_baud,
   output logic        rsp_found
);

   localparam logic [23:0] Limit = 24'((DIVIDER_MAX + 1) * CLOCK_DIVISOR_MAX);
   localparam bit EmptyRange = (DIVIDER_MIN > DIVIDER_MAX);

   bds_state_type state_ff, state_in;

   logic [31:0] ref_clk_ff, ref_clk_in;
   logic [31:0] baud_ff, baud_in;
   logic [31:0] clk_ff, clk_in;
   logic        pre_ff, pre_in;
   logic [7:0]  bdiv_ff, bdiv_in;
   logic [DIVISOR_WIDTH-1:0] span_ff, span_in;
   logic [15:0] cd_ff, cd_in;
   logic        found_ff, found_in;
   logic [31:0] best_err_ff, best_err_in;
   logic [15:0] best_cd_ff, best_cd_in;
   logic [7:0]  best_bdiv_ff, best_bdiv_in;
   logic [31:0] best_rate_ff, best_rate_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_pre_ff, rsp_pre_in;
   logic [15:0] rsp_cd_ff, rsp_cd_in;
   logic [7:0]  rsp_bdiv_ff, rsp_bdiv_in;
   logic [31:0] rsp_rate_ff, rsp_rate_in;
   logic        rsp_found_ff, rsp_found_in;

   logic                      div_start;
   logic [DIVISOR_WIDTH-1:0]  div_divisor;
   logic                      div_done;
   logic [DIVIDEND_WIDTH-1:0] div_quotient;

   logic [8:0]  mult;
   logic [DIVISOR_WIDTH-1:0] span_prod;
   logic [24:0] den_prod;
   logic [56:0] pre_bound;
   logic [31:0] err;

   assign mult      = {1'b0, bdiv_ff} + 9'd1;
   assign span_prod = DIVISOR_WIDTH'(baud_ff) * DIVISOR_WIDTH'(mult);
   assign den_prod  = 25'(cd_ff) * 25'(mult);
   assign pre_bound = 57'({1'b0, baud_ff} + 33'd1) * 57'(Limit);
   assign err       = (baud_ff > div_quotient) ? (baud_ff - div_quotient)
                                               : (div_quotient - baud_ff);

   assign div_start   = (state_ff == ST_CD) || (state_ff == ST_RATE);
   assign div_divisor = span_ff;

   bds_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (clk_ff),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      ref_clk_in   = ref_clk_ff;
      baud_in      = baud_ff;
      clk_in       = clk_ff;
      pre_in       = pre_ff;
      bdiv_in      = bdiv_ff;
      span_in      = span_ff;
      cd_in        = cd_ff;
      found_in     = found_ff;
      best_err_in  = best_err_ff;
      best_cd_in   = best_cd_ff;
      best_bdiv_in = best_bdiv_ff;
      best_rate_in = best_rate_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pre_in   = rsp_pre_ff;
      rsp_cd_in    = rsp_cd_ff;
      rsp_bdiv_in  = rsp_bdiv_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_found_in = rsp_found_ff;

      if (csr_valid) begin
         ref_clk_in = csr_reference_clock_hz;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               baud_in      = req_desired_baud;
               clk_in       = ref_clk_ff;
               pre_in       = 1'b0;
               found_in     = 1'b0;
               best_err_in  = '0;
               best_cd_in   = '0;
               best_bdiv_in = '0;
               best_rate_in = '0;
               state_in     = ST_PRE;
            end
         end
         ST_PRE: begin
            // baud below clock / limit is the same as (baud + 1) * limit <= clock
            if (pre_bound <= 57'(clk_ff)) begin
               pre_in = 1'b1;
               clk_in = clk_ff >> PRESCALE_SHIFT;
            end
            bdiv_in = 8'(DIVIDER_MIN);
            if (baud_ff == '0 || EmptyRange) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: begin
            span_in  = span_prod;
            state_in = ST_CD;
         end
         ST_CD: begin
            state_in = ST_CD_WAIT;
         end
         ST_CD_WAIT: begin
            if (div_done) begin
               if (div_quotient == '0 || div_quotient > 32'(CLOCK_DIVISOR_MAX)) begin
                  state_in = ST_NEXT;
               end else begin
                  cd_in    = div_quotient[15:0];
                  state_in = ST_RATE_MUL;
               end
            end
         end
         ST_RATE_MUL: begin
            span_in  = DIVISOR_WIDTH'(den_prod);
            state_in = ST_RATE;
         end
         ST_RATE: begin
            state_in = ST_RATE_WAIT;
         end
         ST_RATE_WAIT: begin
            if (div_done) begin
               state_in = ST_NEXT;
               if (!found_ff || err < best_err_ff) begin
                  found_in     = 1'b1;
                  best_err_in  = err;
                  best_cd_in   = cd_ff;
                  best_bdiv_in = bdiv_ff;
                  best_rate_in = div_quotient;
                  // exact match ends the search
                  if (err == '0) begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_NEXT: begin
            if (bdiv_ff == 8'(DIVIDER_MAX)) begin
               state_in = ST_FINISH;
            end else begin
               bdiv_in  = bdiv_ff + 8'd1;
               state_in = ST_SPAN;
            end
         end
         ST_FINISH: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pre_in   = pre_ff;
               rsp_cd_in    = best_cd_ff;
               rsp_bdiv_in  = best_bdiv_ff;
               rsp_rate_in  = best_rate_ff;
               rsp_found_in = found_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ref_clk_ff   <= REF_CLOCK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ref_clk_ff   <= ref_clk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      baud_ff      <= baud_in;
      clk_ff       <= clk_in;
      pre_ff       <= pre_in;
      bdiv_ff      <= bdiv_in;
      span_ff      <= span_in;
      cd_ff        <= cd_in;
      found_ff     <= found_in;
      best_err_ff  <= best_err_in;
      best_cd_ff   <= best_cd_in;
      best_bdiv_ff <= best_bdiv_in;
      best_rate_ff <= best_rate_in;
      rsp_pre_ff   <= rsp_pre_in;
      rsp_cd_ff    <= rsp_cd_in;
      rsp_bdiv_ff  <= rsp_bdiv_in;
      rsp_rate_ff  <= rsp_rate_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_prescale_by_eight = rsp_pre_ff;
   assign rsp_clock_divisor     = rsp_cd_ff;
   assign rsp_bit_divider       = rsp_bdiv_ff;
   assign rsp_achieved_baud     = rsp_rate_ff;
   assign rsp_found             = rsp_found_ff;

endmodule
